FILE: design/phb_pkg.sv
// ---------------------------------------------------------------------------
// phb_pkg
// shared types and constants for the binned pixel histogram engine
// ---------------------------------------------------------------------------
package phb_pkg;

    localparam int BINS_DEF        = 256;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int PIXEL_W         = 16;
    localparam int STEP_W          = 16;
    localparam int BINS_CFG_W      = 9;
    localparam int BIN_NUM_W       = 8;
    localparam int TOTAL_W         = 32;
    // quotient width of 16*pixel/step for a positive pixel
    localparam int QUO_W           = PIXEL_W - 1 + 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [STEP_W-1:0]     STEP_RESET     = 16'd256;
    localparam logic [BINS_CFG_W-1:0] BINS_CFG_RESET = 9'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MODE  = 2'd2;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [STEP_W-1:0]     step_size;
        logic [BINS_CFG_W-1:0] bins_in_use;
        logic                  round_mode;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: design/phb_front.sv
// ---------------------------------------------------------------------------
// phb_front
// request intake: decodes the opcode, picks the bin and queues the command
// ---------------------------------------------------------------------------
module phb_front #(
    parameter int BINS = phb_pkg::BINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  phb_pkg::t_cfg                   i_cfg,
    input  logic                            start,
    input  phb_pkg::t_op                    i_opcode,
    input  logic signed [phb_pkg::PIXEL_W-1:0] i_pixel_value,
    input  logic [phb_pkg::BIN_NUM_W-1:0]   i_read_bin,
    input  phb_pkg::t_q_status              i_q,
    input  logic                            i_init,
    output logic                            busy,
    output logic                            o_push,
    output phb_pkg::t_op                    o_op,
    output logic [$clog2(BINS)-1:0]         o_idx
);
    import phb_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] BINS_Q = QUO_W'(BINS);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;

    logic [STEP_W-1:0] r_rem, r_div;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;

    logic                    w_accept, w_need_div, w_ge;
    logic [QUO_W-1:0]        w_step_lim, w_lim_now, w_q_now;
    logic signed [PIXEL_W:0] w_sum;
    logic [STEP_W:0]         w_trial, w_diff;

    function automatic logic [IDX_W-1:0] clamp_bin(input logic [QUO_W-1:0] q,
                                                   input logic [QUO_W-1:0] lim);
        logic [QUO_W-1:0] v;
        v = (q >= lim) ? (lim - QUO_W'(1)) : q;
        return v[IDX_W-1:0];
    endfunction

    // bins in use for step mode, held between one and the store size
    always_comb begin
        w_step_lim = QUO_W'(i_cfg.bins_in_use);
        if (w_step_lim == '0) begin
            w_step_lim = QUO_W'(1);
        end else if (w_step_lim > BINS_Q) begin
            w_step_lim = BINS_Q;
        end
    end

    assign w_sum      = {i_pixel_value[PIXEL_W-1], i_pixel_value} + (PIXEL_W+1)'(8);
    assign w_need_div = (i_opcode == OP_ACC) && !i_cfg.round_mode &&
                        !i_pixel_value[PIXEL_W-1] && (|i_pixel_value);

    // bin known at once: read, round mode, or a non-positive pixel in step mode
    always_comb begin
        w_q_now   = '0;
        w_lim_now = BINS_Q;
        case (i_opcode)
            OP_READ: begin
                w_q_now = QUO_W'(i_read_bin);
            end
            OP_ACC: begin
                if (i_cfg.round_mode) begin
                    if (!w_sum[PIXEL_W] && (w_sum != '0)) begin
                        w_q_now = QUO_W'(w_sum[PIXEL_W-1:4]);
                    end
                end else begin
                    w_lim_now = w_step_lim;
                end
            end
            default: begin
                w_q_now = '0;
            end
        endcase
    end

    assign busy     = (r_state != F_IDLE) || i_q.full || i_init;
    assign w_accept = start && !busy;

    // restoring divider, one quotient bit a cycle
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_op    = i_opcode;
        o_idx   = clamp_bin(w_q_now, w_lim_now);
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    if (w_need_div) begin
                        n_state = F_DIV;
                    end else if (i_opcode != OP_NONE) begin
                        o_push = 1'b1;
                    end
                end
            end
            F_DIV: begin
                if (r_cnt == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_op  = OP_ACC;
                o_idx = clamp_bin(r_quo, w_step_lim);
                if (!i_q.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && w_accept && w_need_div) begin
            r_quo <= {i_pixel_value[PIXEL_W-2:0], 4'b0000};
            r_rem <= '0;
            r_div <= (i_cfg.step_size == '0) ? STEP_W'(1) : i_cfg.step_size;
            r_cnt <= CNT_W'(QUO_W - 1);
        end else if (r_state == F_DIV) begin
            r_rem <= w_ge ? w_diff[STEP_W-1:0] : w_trial[STEP_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

FILE: design/phb_queue.sv
// ---------------------------------------------------------------------------
// phb_queue
// short command queue between intake and the counter store
// ---------------------------------------------------------------------------
module phb_queue #(
    parameter int WIDTH = 10,
    parameter int DEPTH = phb_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output phb_pkg::t_q_status  o_status
);
    import phb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: design/phb_back.sv
// ---------------------------------------------------------------------------
// phb_back
// counter store: read-modify-write of one bin, bin readout, clearing sweep
// ---------------------------------------------------------------------------
module phb_back #(
    parameter int BINS        = phb_pkg::BINS_DEF,
    parameter int COUNT_WIDTH = phb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  phb_pkg::t_q_status             i_q,
    input  phb_pkg::t_op                   i_op,
    input  logic [$clog2(BINS)-1:0]        i_idx,
    output logic                           o_pop,
    output logic                           o_init,
    output logic                           o_strobe,
    output logic [phb_pkg::BIN_NUM_W-1:0]  o_bin_number,
    output logic [phb_pkg::TOTAL_W-1:0]    o_bin_total
);
    import phb_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_FETCH = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;

    logic [COUNT_WIDTH-1:0] r_mem [BINS];
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [IDX_W-1:0]       r_clr, r_idx;
    t_op                    r_op;
    logic                   r_init, r_strobe;
    logic [BIN_NUM_W-1:0]   r_bin;
    logic [TOTAL_W-1:0]     r_total;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [COUNT_WIDTH-1:0] w_wdata, w_inc, w_value;
    logic [TOTAL_W-1:0]     w_total;
    logic [BIN_NUM_W-1:0]   w_bin;

    // saturating increment
    assign w_inc   = (&r_rdata) ? r_rdata : r_rdata + COUNT_WIDTH'(1);
    assign w_value = (r_op == OP_ACC) ? w_inc : r_rdata;

    generate
        if (COUNT_WIDTH > TOTAL_W) begin : g_clip
            assign w_total = (|w_value[COUNT_WIDTH-1:TOTAL_W]) ? '1
                                                                : w_value[TOTAL_W-1:0];
        end else begin : g_ext
            assign w_total = TOTAL_W'(w_value);
        end
        if (IDX_W >= BIN_NUM_W) begin : g_bin_cut
            assign w_bin = r_idx[BIN_NUM_W-1:0];
        end else begin : g_bin_ext
            assign w_bin = BIN_NUM_W'(r_idx);
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_inc;
        unique case (r_state)
            B_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == LAST_BIN) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q.empty) begin
                    o_pop = 1'b1;
                    case (i_op)
                        OP_CLEAR:          n_state = B_CLEAR;
                        OP_ACC, OP_READ:   n_state = B_FETCH;
                        default:           n_state = B_IDLE;
                    endcase
                end
            end
            B_FETCH: begin
                w_we    = (r_op == OP_ACC);
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_init   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == B_FETCH);
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
                if (r_clr == LAST_BIN) begin
                    r_init <= 1'b0;
                end
            end else begin
                r_clr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op  <= i_op;
            r_idx <= i_idx;
        end
        if (r_state == B_FETCH) begin
            r_bin   <= w_bin;
            r_total <= w_total;
        end
    end

    // counter store, registered read at the queue head
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_idx];
    end

    assign o_init       = r_init;
    assign o_strobe     = r_strobe;
    assign o_bin_number = r_bin;
    assign o_bin_total  = r_total;

endmodule

FILE: design/pixel_histogram_binned.sv
// ---------------------------------------------------------------------------
// pixel_histogram_binned
// intensity histogram engine with saturating bin counters
// ---------------------------------------------------------------------------
// usage:
//   requests enter on start/busy: a request is taken at a clock edge with
//   start high and busy low. opcode accumulate bins a signed q11.4 pixel,
//   read reports one bin, clear zeroes every bin; opcode 3 is dropped.
//   accumulate and read give one result on o_result_strobe for a single
//   cycle; the receiver cannot stall, so results are never held back.
//   configuration writes go on the i_cfg_* channel, always ready; the user
//   is to make them only while no request is in flight; the block does not enforce it.
// data flow:
//   intake takes a request per cycle, while the queue is not full, into a
//   two-entry queue; the counter store handles an accumulate or read as a
//   registered read, then write-back, and takes the next command only
//   after the write-back. step-mode accumulate with a positive pixel runs
//   the intake divider, one quotient bit a cycle, and the intake takes no
//   new request until the result is pushed. a request goes through the
//   queue, the store read and write-back and the result register before
//   the strobe rises. clear occupies the store while it sweeps every bin.
// reset:
//   a clearing pass zeroes the store bin by bin; busy stays high
//   throughout. registers come up as step 256, 255 bins, step mode.
// ---------------------------------------------------------------------------
module pixel_histogram_binned #(
    parameter int BINS        = phb_pkg::BINS_DEF,
    parameter int COUNT_WIDTH = phb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic signed [phb_pkg::PIXEL_W-1:0] i_pixel_value,
    input  logic [phb_pkg::BIN_NUM_W-1:0]     i_read_bin,
    // result channel
    output logic                              o_result_strobe,
    output logic [phb_pkg::BIN_NUM_W-1:0]     o_bin_number,
    output logic [phb_pkg::TOTAL_W-1:0]       o_bin_total,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [phb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [phb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import phb_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam int Q_W   = 2 + IDX_W;

    // configuration registers
    t_cfg r_cfg;

    // intake to queue
    logic             w_q_push, w_q_pop, w_init;
    t_op              w_push_op;
    logic [IDX_W-1:0] w_push_idx;
    logic [Q_W-1:0]   w_q_head;
    t_q_status        w_q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size   <= STEP_RESET;
            r_cfg.bins_in_use <= BINS_CFG_RESET;
            r_cfg.round_mode  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP_SIZE:   r_cfg.step_size   <= i_cfg_data[STEP_W-1:0];
                CFG_BINS_IN_USE: r_cfg.bins_in_use <= i_cfg_data[BINS_CFG_W-1:0];
                CFG_ROUND_MODE:  r_cfg.round_mode  <= i_cfg_data[0];
                default: ;  // unused index, write ignored
            endcase
        end
    end

    // front: decode, bin selection, divider for step mode
    phb_front #(
        .BINS (BINS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .start         (start),
        .i_opcode      (t_op'(i_opcode)),
        .i_pixel_value (i_pixel_value),
        .i_read_bin    (i_read_bin),
        .i_q           (w_q_stat),
        .i_init        (w_init),
        .busy          (busy),
        .o_push        (w_q_push),
        .o_op          (w_push_op),
        .o_idx         (w_push_idx)
    );

    // command queue: opcode on top, bin index below
    phb_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_data   ({w_push_op, w_push_idx}),
        .i_pop    (w_q_pop),
        .o_data   (w_q_head),
        .o_status (w_q_stat)
    );

    // back: counter store and result register
    phb_back #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (w_q_stat),
        .i_op         (t_op'(w_q_head[Q_W-1:IDX_W])),
        .i_idx        (w_q_head[IDX_W-1:0]),
        .o_pop        (w_q_pop),
        .o_init       (w_init),
        .o_strobe     (o_result_strobe),
        .o_bin_number (o_bin_number),
        .o_bin_total  (o_bin_total)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_stat.full)
        else $error("command pushed into full queue");

    // requests held off while the store is being cleared after reset
    a_busy_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> busy)
        else $error("request possible during clearing pass");

    // no result while the clearing pass runs
    a_quiet_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !o_result_strobe)
        else $error("result during clearing pass");

    // the store returns to idle after each fetch, so strobes never abut
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("back-to-back result strobes");

endmodule
